// ===== sv/uart_two_byte_pattern_detector_macros.svh =====
// ---------------------------------------------------------------------------
// uart two-byte pattern detector assertion macros
// shared property shorthands, all clocked on clk and disabled in reset
// ---------------------------------------------------------------------------
`ifndef UART_TWO_BYTE_PATTERN_DETECTOR_MACROS_SVH
`define UART_TWO_BYTE_PATTERN_DETECTOR_MACROS_SVH

// same-cycle implication
`define UART2P_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("uart2p same-cycle check failed");

// next-cycle implication
`define UART2P_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("uart2p next-cycle check failed");

`endif

// ===== sv/uart2p_pkg.sv =====
// ---------------------------------------------------------------------------
// uart2p_pkg
// shared types and constants of the uart two-byte pattern detector
// ---------------------------------------------------------------------------
package uart2p_pkg;

    // receiver phases
    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_HUNT  = 3'd1,
        PH_DATA1 = 3'd2,
        PH_STOP1 = 3'd3,
        PH_WAIT2 = 3'd4,
        PH_DATA2 = 3'd5,
        PH_STOP2 = 3'd6
    } phase_t;

    // search status codes
    localparam logic [1:0] STATUS_BUSY    = 2'd0;
    localparam logic [1:0] STATUS_MATCH   = 2'd1;
    localparam logic [1:0] STATUS_TIMEOUT = 2'd2;

    // register indexes
    localparam logic [1:0] REG_BIT_TICKS       = 2'd0;
    localparam logic [1:0] REG_EXPECTED_FIRST  = 2'd1;
    localparam logic [1:0] REG_EXPECTED_SECOND = 2'd2;
    localparam logic [1:0] REG_TIMEOUT_TICKS   = 2'd3;

    // register reset values
    localparam logic [15:0] BIT_TICKS_RST       = 16'd104;
    localparam logic [7:0]  EXPECTED_FIRST_RST  = 8'd84;
    localparam logic [7:0]  EXPECTED_SECOND_RST = 8'd88;
    localparam logic [23:0] TIMEOUT_TICKS_RST   = 24'd300000;

    // frame constants
    localparam logic [3:0]  DATA_BITS  = 4'd8;
    localparam logic [3:0]  WAIT_BITS  = 4'd3;
    localparam logic [23:0] SEARCH_MAX = 24'hFFFFFF;

    typedef struct packed {
        logic [15:0] bit_ticks;
        logic [7:0]  expected_first;
        logic [7:0]  expected_second;
        logic [23:0] timeout_ticks;
    } cfg_t;

    typedef struct packed {
        logic [1:0] search_status;
        logic [7:0] last_first_byte;
        logic [7:0] last_second_byte;
    } result_t;

endpackage

// ===== sv/uart2p_cfg.sv =====
// ---------------------------------------------------------------------------
// uart2p_cfg
// configuration register file, written one register per transaction
// ---------------------------------------------------------------------------
module uart2p_cfg
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [23:0]       cfg_data,
    output uart2p_pkg::cfg_t  cfg
);

    uart2p_pkg::cfg_t cfg_reg;
    uart2p_pkg::cfg_t cfg_next;

    // writes are always taken
    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // register decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                uart2p_pkg::REG_BIT_TICKS:       cfg_next.bit_ticks       = cfg_data[15:0];
                uart2p_pkg::REG_EXPECTED_FIRST:  cfg_next.expected_first  = cfg_data[7:0];
                uart2p_pkg::REG_EXPECTED_SECOND: cfg_next.expected_second = cfg_data[7:0];
                uart2p_pkg::REG_TIMEOUT_TICKS:   cfg_next.timeout_ticks   = cfg_data;
                default:                         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.bit_ticks       <= uart2p_pkg::BIT_TICKS_RST;
            cfg_reg.expected_first  <= uart2p_pkg::EXPECTED_FIRST_RST;
            cfg_reg.expected_second <= uart2p_pkg::EXPECTED_SECOND_RST;
            cfg_reg.timeout_ticks   <= uart2p_pkg::TIMEOUT_TICKS_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== sv/uart2p_core.sv =====
// ---------------------------------------------------------------------------
// uart2p_core
// receiver state machine, bit timing, byte assembly and pattern compare
// ---------------------------------------------------------------------------
module uart2p_core
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 adv,
    input  logic                 line_level,
    input  logic                 begin_search,
    input  uart2p_pkg::cfg_t     cfg,
    output uart2p_pkg::result_t  result
);

    uart2p_pkg::phase_t phase_reg;
    uart2p_pkg::phase_t phase_next;
    logic [16:0] bit_timer_reg;
    logic [16:0] bit_timer_next;
    logic [3:0]  bit_index_reg;
    logic [3:0]  bit_index_next;
    logic [7:0]  shift_byte_reg;
    logic [7:0]  shift_byte_next;
    logic [7:0]  held_first_reg;
    logic [7:0]  held_first_next;
    logic [7:0]  held_second_reg;
    logic [7:0]  held_second_next;
    logic [23:0] search_timer_reg;
    logic [23:0] search_timer_next;
    logic [1:0]  status;

    logic [15:0] one_bit;
    logic [16:0] frame_timer;
    logic [16:0] timer_dec;
    logic [23:0] search_inc;
    logic [3:0]  index_inc;
    logic [7:0]  shift_in;

    // shared arithmetic
    assign one_bit     = (cfg.bit_ticks == 16'd0) ? 16'd1 : cfg.bit_ticks;
    assign frame_timer = {1'b0, one_bit} + {2'b00, one_bit[15:1]};
    assign timer_dec   = (bit_timer_reg != 17'd0) ? (bit_timer_reg - 17'd1) : 17'd0;
    assign search_inc  = (search_timer_reg != uart2p_pkg::SEARCH_MAX)
                       ? (search_timer_reg + 24'd1) : search_timer_reg;
    assign index_inc   = bit_index_reg + 4'd1;
    assign shift_in    = shift_byte_reg | (8'(line_level) << bit_index_reg[2:0]);

    // next state and status
    always_comb
    begin
        phase_next        = phase_reg;
        bit_timer_next    = bit_timer_reg;
        bit_index_next    = bit_index_reg;
        shift_byte_next   = shift_byte_reg;
        held_first_next   = held_first_reg;
        held_second_next  = held_second_reg;
        search_timer_next = search_timer_reg;
        status            = uart2p_pkg::STATUS_BUSY;

        if (begin_search)
        begin
            phase_next        = uart2p_pkg::PH_HUNT;
            search_timer_next = 24'd0;
            bit_timer_next    = 17'd0;
            bit_index_next    = 4'd0;
            shift_byte_next   = 8'd0;
        end
        else if (phase_reg != uart2p_pkg::PH_IDLE)
        begin
            search_timer_next = search_inc;
            unique case (phase_reg)
                uart2p_pkg::PH_HUNT:
                begin
                    if (search_inc >= cfg.timeout_ticks)
                    begin
                        status     = uart2p_pkg::STATUS_TIMEOUT;
                        phase_next = uart2p_pkg::PH_IDLE;
                    end
                    else if (!line_level)
                    begin
                        phase_next      = uart2p_pkg::PH_DATA1;
                        bit_timer_next  = frame_timer;
                        bit_index_next  = 4'd0;
                        shift_byte_next = 8'd0;
                    end
                end
                uart2p_pkg::PH_DATA1,
                uart2p_pkg::PH_DATA2:
                begin
                    if (timer_dec != 17'd0)
                    begin
                        bit_timer_next = timer_dec;
                    end
                    else
                    begin
                        shift_byte_next = shift_in;
                        bit_index_next  = index_inc;
                        bit_timer_next  = {1'b0, one_bit};
                        if (index_inc >= uart2p_pkg::DATA_BITS)
                        begin
                            if (phase_reg == uart2p_pkg::PH_DATA1)
                            begin
                                held_first_next = shift_in;
                                phase_next      = uart2p_pkg::PH_STOP1;
                            end
                            else
                            begin
                                held_second_next = shift_in;
                                phase_next       = uart2p_pkg::PH_STOP2;
                            end
                        end
                    end
                end
                uart2p_pkg::PH_STOP1:
                begin
                    bit_timer_next = timer_dec;
                    if (timer_dec == 17'd0)
                    begin
                        phase_next     = uart2p_pkg::PH_WAIT2;
                        bit_timer_next = {1'b0, one_bit};
                        bit_index_next = 4'd0;
                    end
                end
                uart2p_pkg::PH_WAIT2:
                begin
                    if (!line_level)
                    begin
                        phase_next      = uart2p_pkg::PH_DATA2;
                        bit_timer_next  = frame_timer;
                        bit_index_next  = 4'd0;
                        shift_byte_next = 8'd0;
                    end
                    else
                    begin
                        bit_timer_next = timer_dec;
                        if (timer_dec == 17'd0)
                        begin
                            bit_index_next = index_inc;
                            if (index_inc >= uart2p_pkg::WAIT_BITS)
                            begin
                                phase_next     = uart2p_pkg::PH_HUNT;
                                bit_index_next = 4'd0;
                            end
                            else
                            begin
                                bit_timer_next = {1'b0, one_bit};
                            end
                        end
                    end
                end
                uart2p_pkg::PH_STOP2:
                begin
                    bit_timer_next = timer_dec;
                    if (timer_dec == 17'd0)
                    begin
                        bit_index_next = 4'd0;
                        if (held_first_reg == cfg.expected_first &&
                            held_second_reg == cfg.expected_second)
                        begin
                            status     = uart2p_pkg::STATUS_MATCH;
                            phase_next = uart2p_pkg::PH_IDLE;
                        end
                        else
                        begin
                            phase_next = uart2p_pkg::PH_HUNT;
                        end
                    end
                end
                default:
                begin
                    phase_next = uart2p_pkg::PH_IDLE;
                end
            endcase
        end
    end

    // result of this transaction, taken by the output register
    assign result.search_status    = status;
    assign result.last_first_byte  = held_first_next;
    assign result.last_second_byte = held_second_next;

    // state machine register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= uart2p_pkg::PH_IDLE;
        end
        else if (adv)
        begin
            phase_reg <= phase_next;
        end
    end

    // datapath state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_timer_reg    <= 17'd0;
            bit_index_reg    <= 4'd0;
            shift_byte_reg   <= 8'd0;
            held_first_reg   <= 8'd0;
            held_second_reg  <= 8'd0;
            search_timer_reg <= 24'd0;
        end
        else if (adv)
        begin
            bit_timer_reg    <= bit_timer_next;
            bit_index_reg    <= bit_index_next;
            shift_byte_reg   <= shift_byte_next;
            held_first_reg   <= held_first_next;
            held_second_reg  <= held_second_next;
            search_timer_reg <= search_timer_next;
        end
    end

endmodule

// ===== sv/uart2p_out_stage.sv =====
// ---------------------------------------------------------------------------
// uart2p_out_stage
// result register with valid/stall handshake toward the consumer
// ---------------------------------------------------------------------------
module uart2p_out_stage
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  uart2p_pkg::result_t  result,
    output logic                 busy,
    output logic                 out_valid,
    input  logic                 out_stall,
    output uart2p_pkg::result_t  out_result
);

    logic                valid_reg;
    logic                valid_next;
    uart2p_pkg::result_t data_reg;

    // register is blocked only while a result waits on a stalled consumer
    assign busy       = valid_reg && out_stall;
    assign valid_next = load || busy;
    assign out_valid  = valid_reg;
    assign out_result = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload needs no reset
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result;
        end
    end

endmodule

// ===== sv/uart_two_byte_pattern_detector.sv =====
// ---------------------------------------------------------------------------
// uart two-byte pattern detector
// result: registered, valid in the cycle after its line sample is accepted
// throughput: one sample per cycle; input stalls only while a result is stalled
// reset: asynchronous, clears phase, timers, held bytes and registers to defaults
// ---------------------------------------------------------------------------
`include "uart_two_byte_pattern_detector_macros.svh"

module uart_two_byte_pattern_detector
(
    input  logic        clk,
    input  logic        rst_n,
    // line sample channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        line_level,
    input  logic        begin_search,
    // result channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  search_status,
    output logic [7:0]  last_first_byte,
    output logic [7:0]  last_second_byte,
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_data
);

    uart2p_pkg::cfg_t    cfg;
    uart2p_pkg::result_t result;
    uart2p_pkg::result_t out_result;
    logic                in_accept;
    logic                out_accept;
    logic                out_busy;

    // handshake
    assign in_stall   = out_busy;
    assign in_accept  = in_valid && !out_busy;
    assign out_accept = out_valid && !out_stall;

    uart2p_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    uart2p_core u_core
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .adv          (in_accept),
        .line_level   (line_level),
        .begin_search (begin_search),
        .cfg          (cfg),
        .result       (result)
    );

    uart2p_out_stage u_out
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (in_accept),
        .result     (result),
        .busy       (out_busy),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_result (out_result)
    );

    assign search_status    = out_result.search_status;
    assign last_first_byte  = out_result.last_first_byte;
    assign last_second_byte = out_result.last_second_byte;

    // every accepted sample yields a result next cycle
    `UART2P_ASSERT_NEXT(a_accept_gives_result, in_accept, out_valid)
    // arming a search always reports busy
    `UART2P_ASSERT_NEXT(a_arm_reports_busy, in_accept && begin_search,
                        search_status == uart2p_pkg::STATUS_BUSY)
    // a drained result with nothing new behind it leaves the register empty
    `UART2P_ASSERT_NEXT(a_drain_empties, out_accept && !in_accept, !out_valid)

endmodule

// ===== dv/tb.sv =====
// ---------------------------------------------------------------------------
// tb: uart two-byte pattern detector testbench
// drives serial line samples through the valid/stall channel and checks every
// status report against a cycle-level receiver model kept in the bench
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

    typedef struct packed {
        logic line;
        logic arm;
    } line_sample_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        line_level = 1'b1;
    logic        begin_search = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  search_status;
    logic [7:0]  last_first_byte;
    logic [7:0]  last_second_byte;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = uart2p_pkg::REG_BIT_TICKS;
    logic [23:0] cfg_data = '0;

    // stimulus and expected reports
    line_sample_t        line_samples[$];
    uart2p_pkg::result_t predicted_reports[$];
    line_sample_t        drive_sample;
    logic                sample_taken = 1'b0;
    logic                jitter_on = 1'b1;
    int                  err_count = 0;
    int                  rx_hold_reqs = 0;
    int                  rx_hold_seen = 0;
    int                  rx_hold_left = 0;

    // receiver model state and register mirror
    uart2p_pkg::cfg_t    model_cfg = '{uart2p_pkg::BIT_TICKS_RST,
                                       uart2p_pkg::EXPECTED_FIRST_RST,
                                       uart2p_pkg::EXPECTED_SECOND_RST,
                                       uart2p_pkg::TIMEOUT_TICKS_RST};
    uart2p_pkg::phase_t  rx_phase = uart2p_pkg::PH_IDLE;
    logic [16:0]         rx_bit_timer = '0;
    logic [3:0]          rx_bit_index = '0;
    logic [7:0]          rx_shift = '0;
    logic [7:0]          rx_first = '0;
    logic [7:0]          rx_second = '0;
    logic [23:0]         rx_search_timer = '0;

    uart_two_byte_pattern_detector DUT
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .line_level       (line_level),
        .begin_search     (begin_search),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .search_status    (search_status),
        .last_first_byte  (last_first_byte),
        .last_second_byte (last_second_byte),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    // clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // run limit
    initial
    begin
        #5000000;
        $display("Some tests failed");
        $finish;
    end

    // one serial bit in ticks, zero counts as one
    function automatic logic [16:0] bit_len();
        return (model_cfg.bit_ticks == 16'd0) ? 17'd1 : {1'b0, model_cfg.bit_ticks};
    endfunction

    // start edge seen: first data sample lands 1.5 bit times later
    function automatic void open_frame(uart2p_pkg::phase_t next_ph);
        logic [16:0] b;
        b = bit_len();
        rx_phase = next_ph;
        rx_bit_timer = b + (b >> 1);
        rx_bit_index = '0;
        rx_shift = '0;
    endfunction

    // count down one data bit, true once the eighth bit is in
    function automatic logic shift_in_bit(logic line);
        if (rx_bit_timer != 17'd0)
            rx_bit_timer--;
        if (rx_bit_timer != 17'd0)
            return 1'b0;
        rx_shift = rx_shift | (8'(line) << rx_bit_index[2:0]);
        rx_bit_index++;
        rx_bit_timer = bit_len();
        return rx_bit_index >= uart2p_pkg::DATA_BITS;
    endfunction

    // advance the receiver one tick and form its report
    function automatic uart2p_pkg::result_t advance_receiver(logic line, logic arm);
        uart2p_pkg::result_t r;
        r.search_status = uart2p_pkg::STATUS_BUSY;
        if (arm)
        begin
            rx_phase = uart2p_pkg::PH_HUNT;
            rx_search_timer = '0;
            rx_bit_timer = '0;
            rx_bit_index = '0;
            rx_shift = '0;
        end
        else if (rx_phase != uart2p_pkg::PH_IDLE)
        begin
            if (rx_search_timer < uart2p_pkg::SEARCH_MAX)
                rx_search_timer++;
            case (rx_phase)
                uart2p_pkg::PH_HUNT:
                begin
                    if (rx_search_timer >= model_cfg.timeout_ticks)
                    begin
                        r.search_status = uart2p_pkg::STATUS_TIMEOUT;
                        rx_phase = uart2p_pkg::PH_IDLE;
                    end
                    else if (!line)
                        open_frame(uart2p_pkg::PH_DATA1);
                end
                uart2p_pkg::PH_DATA1:
                begin
                    if (shift_in_bit(line))
                    begin
                        rx_first = rx_shift;
                        rx_phase = uart2p_pkg::PH_STOP1;
                    end
                end
                uart2p_pkg::PH_STOP1:
                begin
                    if (rx_bit_timer != 17'd0)
                        rx_bit_timer--;
                    if (rx_bit_timer == 17'd0)
                    begin
                        rx_phase = uart2p_pkg::PH_WAIT2;
                        rx_bit_timer = bit_len();
                        rx_bit_index = '0;
                    end
                end
                uart2p_pkg::PH_WAIT2:
                begin
                    if (!line)
                        open_frame(uart2p_pkg::PH_DATA2);
                    else
                    begin
                        if (rx_bit_timer != 17'd0)
                            rx_bit_timer--;
                        if (rx_bit_timer == 17'd0)
                        begin
                            rx_bit_index++;
                            if (rx_bit_index >= uart2p_pkg::WAIT_BITS)
                            begin
                                rx_phase = uart2p_pkg::PH_HUNT;
                                rx_bit_index = '0;
                            end
                            else
                                rx_bit_timer = bit_len();
                        end
                    end
                end
                uart2p_pkg::PH_DATA2:
                begin
                    if (shift_in_bit(line))
                    begin
                        rx_second = rx_shift;
                        rx_phase = uart2p_pkg::PH_STOP2;
                    end
                end
                uart2p_pkg::PH_STOP2:
                begin
                    if (rx_bit_timer != 17'd0)
                        rx_bit_timer--;
                    if (rx_bit_timer == 17'd0)
                    begin
                        rx_bit_index = '0;
                        if (rx_first == model_cfg.expected_first &&
                            rx_second == model_cfg.expected_second)
                        begin
                            r.search_status = uart2p_pkg::STATUS_MATCH;
                            rx_phase = uart2p_pkg::PH_IDLE;
                        end
                        else
                            rx_phase = uart2p_pkg::PH_HUNT;
                    end
                end
                default: rx_phase = uart2p_pkg::PH_IDLE;
            endcase
        end
        r.last_first_byte = rx_first;
        r.last_second_byte = rx_second;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got)
        begin
            err_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // monitor: check result transactions, then predict for accepted samples
    always @(posedge clk)
    begin
        uart2p_pkg::result_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (predicted_reports.size() == 0)
                begin
                    err_count++;
                    $display("%0t: unexpected result, expected none, actual %0d/%0d/%0d",
                             $time, search_status, last_first_byte, last_second_byte);
                end
                else
                begin
                    want = predicted_reports.pop_front();
                    check_field("search_status", 8'(want.search_status), 8'(search_status));
                    check_field("last_first_byte", want.last_first_byte, last_first_byte);
                    check_field("last_second_byte", want.last_second_byte, last_second_byte);
                end
            end
            sample_taken = in_valid && !in_stall;
            if (sample_taken)
                predicted_reports.push_back(advance_receiver(line_level, begin_search));
        end
        else
            sample_taken = 1'b0;
    end

    // driver: offer the next line sample once the last one was taken
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || sample_taken))
        begin
            if (line_samples.size() != 0 && !(jitter_on && $urandom_range(99) < 8))
            begin
                drive_sample = line_samples.pop_front();
                in_valid <= 1'b1;
                line_level <= drive_sample.line;
                begin_search <= drive_sample.arm;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // result receiver: random stall, plus a long hold-off on request
    always @(negedge clk)
    begin
        if (rx_hold_left != 0)
        begin
            out_stall <= 1'b1;
            rx_hold_left <= rx_hold_left - 1;
        end
        else if (rx_hold_reqs != rx_hold_seen)
        begin
            rx_hold_seen <= rx_hold_reqs;
            rx_hold_left <= 60;
            out_stall <= 1'b1;
        end
        else
            out_stall <= jitter_on && ($urandom_range(99) < 8);
    end

    task automatic push_sample(input logic line, input logic arm);
        line_sample_t s;
        s.line = line;
        s.arm = arm;
        line_samples.push_back(s);
    endtask

    task automatic push_level(input logic line, input int unsigned n);
        repeat (n) push_sample(line, 1'b0);
    endtask

    // one 8n1 frame, bt ticks per bit
    task automatic push_frame(input logic [7:0] data, input int unsigned bt);
        int k;
        push_level(1'b0, bt);
        for (k = 0; k < 8; k++)
            push_level(data[k], bt);
        push_level(1'b1, bt);
    endtask

    // search, usually armed, with two frames, mostly the expected pair
    task automatic push_attempt(input int unsigned bt);
        logic [7:0]  b1;
        logic [7:0]  b2;
        int unsigned sel;
        sel = $urandom_range(99);
        b1 = model_cfg.expected_first;
        b2 = model_cfg.expected_second;
        if (sel < 15)
            b1 = 8'($urandom);
        else if (sel < 30)
            b2 = b2 ^ (8'h01 << $urandom_range(7));
        if ($urandom_range(9) != 0)
            push_sample(1'($urandom_range(1)), 1'b1);
        push_level(1'b1, $urandom_range(0, 3 * bt));
        push_frame(b1, bt);
        // second start bit too late for the wait window
        if (sel >= 30 && sel < 38)
            push_level(1'b1, 4 * bt);
        else
            push_level(1'b1, $urandom_range(0, 2 * bt));
        push_frame(b2, bt);
        push_level(1'b1, $urandom_range(0, bt));
    endtask

    // mostly well-formed searches, some noise and cut-off frames
    task automatic push_random_mix(input int unsigned bt, input int target);
        int unsigned r;
        while (line_samples.size() < target)
        begin
            r = $urandom_range(99);
            if (r < 80)
                push_attempt(bt);
            else if (r < 92)
                repeat ($urandom_range(1, 20))
                    push_sample(1'($urandom_range(1)), $urandom_range(99) < 5);
            else
            begin
                push_level(1'b0, bt);
                repeat ($urandom_range(1, 12))
                    push_sample(1'($urandom_range(1)), 1'b0);
            end
        end
    endtask

    // wait until every sample is taken and every report has come back
    task automatic quiesce();
        do
        begin
            @(negedge clk);
            #1;
        end
        while (line_samples.size() != 0 || in_valid || predicted_reports.size() != 0);
        repeat (3) @(negedge clk);
        #1;
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [23:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            uart2p_pkg::REG_BIT_TICKS:       model_cfg.bit_ticks = data[15:0];
            uart2p_pkg::REG_EXPECTED_FIRST:  model_cfg.expected_first = data[7:0];
            uart2p_pkg::REG_EXPECTED_SECOND: model_cfg.expected_second = data[7:0];
            uart2p_pkg::REG_TIMEOUT_TICKS:   model_cfg.timeout_ticks = data;
            default: ;
        endcase
    endtask

    task automatic write_regs(input uart2p_pkg::cfg_t c);
        write_reg(uart2p_pkg::REG_BIT_TICKS, 24'(c.bit_ticks));
        write_reg(uart2p_pkg::REG_EXPECTED_FIRST, 24'(c.expected_first));
        write_reg(uart2p_pkg::REG_EXPECTED_SECOND, 24'(c.expected_second));
        write_reg(uart2p_pkg::REG_TIMEOUT_TICKS, c.timeout_ticks);
        @(negedge clk);
        cfg_valid <= 1'b0;
        #1;
    endtask

    // sequence of phases
    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        #1;

        // defaults: ignored samples while idle, arming tick, re-arm mid-search
        push_level(1'b1, 2);
        push_sample(1'b0, 1'b0);
        push_sample(1'b0, 1'b1);
        push_level(1'b1, 2);
        push_sample(1'b0, 1'b0);
        push_sample(1'b1, 1'b1);
        push_sample(1'b1, 1'b0);
        quiesce();

        // zero timeout ends on the first hunting tick even with a low line
        write_regs('{16'd0, 8'h00, 8'hFF, 24'd0});
        push_sample(1'b1, 1'b1);
        push_sample(1'b0, 1'b0);
        push_sample(1'b0, 1'b0);
        quiesce();

        // zero bit time treated as one tick, extreme pattern bytes
        write_regs('{16'd0, 8'h00, 8'hFF, 24'hFFFFFF});
        push_sample(1'b1, 1'b1);
        push_frame(8'h00, 1);
        push_frame(8'hFF, 1);
        push_level(1'b1, 1);
        quiesce();

        // longest bit time: no timeout inside a frame
        write_regs('{16'hFFFF, 8'hFF, 8'h00, 24'd3});
        push_sample(1'b1, 1'b1);
        push_sample(1'b0, 1'b0);
        push_level(1'b1, 4);
        push_sample(1'b0, 1'b0);
        quiesce();

        // shortest nonzero timeout
        write_regs('{16'd1, 8'hA5, 8'h5A, 24'd1});
        push_sample(1'b1, 1'b1);
        push_sample(1'b1, 1'b0);
        push_sample(1'b0, 1'b0);
        quiesce();

        // random phase, two-tick bits, timeouts likely
        write_regs('{16'd2, 8'($urandom), 8'($urandom), 24'($urandom_range(40, 160))});
        push_random_mix(2, 200);
        quiesce();

        // no idling; receiver holds off while samples keep coming
        jitter_on = 1'b0;
        write_regs('{16'd3, 8'($urandom), 8'($urandom), 24'd200});
        push_random_mix(3, 200);
        while (line_samples.size() > 150)
            @(posedge clk);
        rx_hold_reqs++;
        quiesce();

        // wider bits, larger window
        jitter_on = 1'b1;
        write_regs('{16'($urandom_range(4, 6)), 8'($urandom), 8'($urandom),
                     24'($urandom_range(200, 2000))});
        push_random_mix(32'(model_cfg.bit_ticks), 200);
        quiesce();

        repeat (10) @(posedge clk);
        if (err_count == 0 && predicted_reports.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
